@@ hdl/barrier_cavity_energy_kick_macros.svh @@
// Assertion macros for the checker file.
`ifndef BARRIER_CAVITY_ENERGY_KICK_MACROS_SVH
`define BARRIER_CAVITY_ENERGY_KICK_MACROS_SVH

// Checked only while out of reset.
`define BCEK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bcek: assertion failed");

// Checked on every edge, reset included.
`define BCEK_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bcek: assertion failed");

`endif

@@ hdl/bcek_pkg.sv @@
// Types and constants of the barrier cavity energy kick block.
package bcek_pkg;

  typedef struct packed {
    logic signed [31:0] position_z;
    logic signed [31:0] energy_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] energy_out;
    logic               saturated;
  } out_beat_t;

  typedef enum logic [2:0] {
    REG_Z_TO_PHASE   = 3'd0,
    REG_VOLTAGE      = 3'd1,
    REG_PLUS_CENTRE  = 3'd2,
    REG_MINUS_CENTRE = 3'd3,
    REG_PLUS_HALF_W  = 3'd4,
    REG_MINUS_HALF_W = 3'd5
  } cfg_reg_e;

  localparam int unsigned PhW   = 50;
  localparam int unsigned RadW  = 37;
  localparam int unsigned WRadW = 36;
  localparam int unsigned CosW  = 31;

  localparam logic signed [PhW-1:0] PiQ32    = 50'sd13493037705;
  localparam logic signed [PhW-1:0] TwoPiQ32 = 50'sd26986075409;
  localparam logic [52:0]           Deg2RadQ32 = 53'd74961321;
  localparam longint unsigned       HalfPiQ30  = 64'd1686629713;
  localparam longint unsigned       OneQ30     = 64'd1073741824;

  localparam logic signed [31:0]    ZToPhaseReset = 32'sd16777216;
  localparam logic [WRadW-1:0]      HalfWidthRadReset = 36'd74961321;

endpackage

@@ hdl/barrier_cavity_energy_kick.sv @@
// Throughput: one beat per cycle unless out_ready_i stalls the output; the table index
//   divider retires one quotient bit per stage, so its depth follows the table size.
// Reset: clears all stage valids and loads register defaults; the cosine table
//   is constant and needs no fill.
module barrier_cavity_energy_kick #(
  parameter int unsigned CosTableDepth = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bcek_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bcek_pkg::out_beat_t  out_beat_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import bcek_pkg::*;

  localparam int unsigned IdxW   = $clog2(CosTableDepth);
  localparam int unsigned NumW   = WRadW + IdxW;
  localparam int unsigned SPhase = 1;
  localparam int unsigned SDiff  = 2;
  localparam int unsigned SNum   = 3;
  localparam int unsigned SRom   = SNum + IdxW + 1;
  localparam int unsigned SMul   = SRom + 1;
  localparam int unsigned SKick  = SMul + 1;
  localparam int unsigned NS     = SKick + 2;

  typedef struct packed {
    logic signed [31:0] energy;
    logic [1:0]         in_win;
  } side_t;

  // configuration, angles held in Q32 radians
  logic signed [31:0]      k_q, v_q;
  logic signed [RadW-1:0]  c_q [2];
  logic [WRadW-1:0]        w_q [2];
  logic signed [52:0]      cdeg_prod;
  logic [52:0]             wdeg_prod;

  assign cfg_ready_o = 1'b1;
  assign cdeg_prod = $signed({{28{cfg_data_i[24]}}, cfg_data_i[24:0]}) * $signed(Deg2RadQ32);
  assign wdeg_prod = {29'b0, cfg_data_i[23:0]} * Deg2RadQ32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= ZToPhaseReset;
      v_q    <= '0;
      c_q[0] <= '0;
      c_q[1] <= '0;
      w_q[0] <= HalfWidthRadReset;
      w_q[1] <= HalfWidthRadReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_Z_TO_PHASE:   k_q    <= cfg_data_i;
        REG_VOLTAGE:      v_q    <= cfg_data_i;
        REG_PLUS_CENTRE:  c_q[0] <= cdeg_prod[52:16];
        REG_MINUS_CENTRE: c_q[1] <= cdeg_prod[52:16];
        REG_PLUS_HALF_W:  w_q[0] <= wdeg_prod[51:16];
        REG_MINUS_HALF_W: w_q[1] <= wdeg_prod[51:16];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NS-1:0] vld_q, vld_in, rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign vld_in     = {vld_q[NS-2:0], in_valid_i};
  assign in_ready_o = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) vld_q[s] <= vld_in[s];
      end
    end
  end

  // energy and window flags ride along
  side_t       side_q [SKick+1];
  side_t       side_d [SKick+1];
  logic [1:0]  inwin_d;

  always_comb begin
    side_d[0] = '{energy: in_beat_i.energy_in, in_win: 2'b00};
    for (int s = 1; s <= SKick; s++) begin
      side_d[s] = side_q[s-1];
    end
    side_d[SDiff].in_win = inwin_d;
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= SKick; s++) begin
      if (rdy[s]) side_q[s] <= side_d[s];
    end
  end

  // position times factor
  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      prod_q <= $signed({{32{in_beat_i.position_z[31]}}, in_beat_i.position_z})
              * $signed({{32{k_q[31]}}, k_q});
    end
  end

  // phase with a single wrap
  logic signed [64:0]    neg_prod;
  logic signed [PhW-1:0] ph0, ph1, ph2, ph_q;

  always_comb begin
    neg_prod = -$signed({prod_q[63], prod_q});
    ph0 = $signed({neg_prod[64], neg_prod[64:16]});
    ph1 = (ph0 < -PiQ32) ? ph0 + TwoPiQ32 : ph0;
    ph2 = (ph1 > PiQ32) ? ph1 - TwoPiQ32 : ph1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SPhase]) ph_q <= ph2;
  end

  // distance to centre, window test, divider
  logic [WRadW-1:0] ad_q [2];
  logic [WRadW-1:0] ad_d [2];
  logic [WRadW-1:0] r_q  [IdxW+1][2];
  logic [IdxW-1:0]  nl_q [IdxW+1][2];
  logic [IdxW-1:0]  q_q  [IdxW+1][2];
  logic [NumW-1:0]  num  [2];

  for (genvar j = 0; j < 2; j++) begin : g_win
    logic signed [PhW:0] d;
    logic [PhW:0]        dabs;

    always_comb begin
      d       = $signed({ph_q[PhW-1], ph_q}) - $signed({{(PhW+1-RadW){c_q[j][RadW-1]}}, c_q[j]});
      dabs    = d[PhW] ? -d : d;
      inwin_d[j] = (w_q[j] != '0) && (dabs < {{(PhW+1-WRadW){1'b0}}, w_q[j]});
      ad_d[j] = inwin_d[j] ? dabs[WRadW-1:0] : '0;
      num[j]  = {{IdxW{1'b0}}, ad_q[j]} * NumW'(CosTableDepth);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[SDiff]) ad_q[j] <= ad_d[j];
      if (rdy[SNum]) begin
        r_q[0][j]  <= num[j][NumW-1:IdxW];
        nl_q[0][j] <= num[j][IdxW-1:0];
        q_q[0][j]  <= '0;
      end
    end

    for (genvar t = 0; t < IdxW; t++) begin : g_step
      logic [WRadW:0] trial;
      logic           ge;

      always_comb begin
        trial = {r_q[t][j], nl_q[t][j][IdxW-1]};
        ge    = trial >= {1'b0, w_q[j]};
      end

      always_ff @(posedge clk_i) begin
        if (rdy[SNum+1+t]) begin
          r_q[t+1][j]  <= ge ? WRadW'(trial - {1'b0, w_q[j]}) : trial[WRadW-1:0];
          nl_q[t+1][j] <= {nl_q[t][j][IdxW-2:0], 1'b0};
          q_q[t+1][j]  <= {q_q[t][j][IdxW-2:0], ge};
        end
      end
    end
  end

  // table lookup
  logic [CosW-1:0] cos_p, cos_m;

  bcek_cos_rom #(
    .Depth (CosTableDepth),
    .IdxW  (IdxW)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (rdy[SRom]),
    .idx_p_i (q_q[IdxW][0]),
    .idx_m_i (q_q[IdxW][1]),
    .cos_p_o (cos_p),
    .cos_m_o (cos_m)
  );

  // voltage times cosine
  logic signed [63:0] mp_q, mm_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SMul]) begin
      mp_q <= $signed({{32{v_q[31]}}, v_q}) * $signed({33'b0, cos_p});
      mm_q <= $signed({{32{v_q[31]}}, v_q}) * $signed({33'b0, cos_m});
    end
  end

  // round half up, negative window wins
  logic signed [63:0] rp, rm;
  logic signed [34:0] kick_d, kick_q;

  always_comb begin
    rp = mp_q + 64'sd536870912;
    rm = mm_q + 64'sd536870912;
    if (side_q[SMul].in_win[1])      kick_d = -$signed({rm[63], rm[63:30]});
    else if (side_q[SMul].in_win[0]) kick_d = $signed({rp[63], rp[63:30]});
    else                             kick_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SKick]) kick_q <= kick_d;
  end

  // add and clip
  logic signed [34:0] sum;
  out_beat_t          out_d, out_q;

  always_comb begin
    sum = $signed({{3{side_q[SKick].energy[31]}}, side_q[SKick].energy}) + kick_q;
    if (sum > 35'sd2147483647) begin
      out_d = '{energy_out: 32'sh7fffffff, saturated: 1'b1};
    end else if (sum < -35'sd2147483648) begin
      out_d = '{energy_out: 32'sh80000000, saturated: 1'b1};
    end else begin
      out_d = '{energy_out: sum[31:0], saturated: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) out_q <= out_d;
  end

  assign out_beat_o = out_q;

endmodule

@@ hdl/bcek_cos_rom.sv @@
// Quarter-wave cosine table, Q30, two registered read ports.
module bcek_cos_rom #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned IdxW  = 10
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [IdxW-1:0]              idx_p_i,
  input  logic [IdxW-1:0]              idx_m_i,
  output logic [bcek_pkg::CosW-1:0]    cos_p_o,
  output logic [bcek_pkg::CosW-1:0]    cos_m_o
);
  import bcek_pkg::*;

  typedef logic [CosW-1:0] rom_t [Depth];

  // (2n-1)*2n for the Taylor terms n = 1..8
  localparam longint unsigned TermDiv [8] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };

  function automatic rom_t build_rom();
    rom_t              r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            s;
    for (int i = 0; i < Depth; i++) begin
      x    = (HalfPiQ30 * longint'(i)) / Depth;
      x2   = (x * x) >> 30;
      term = OneQ30;
      s    = longint'(OneQ30);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / TermDiv[n-1];
        if (n[0]) s = s - longint'(term);
        else      s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > longint'(OneQ30)) s = longint'(OneQ30);
      r[i] = s[CosW-1:0];
    end
    return r;
  endfunction

  localparam rom_t CosRom = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_p_o <= CosRom[idx_p_i];
      cos_m_o <= CosRom[idx_m_i];
    end
  end

endmodule

@@ hdl/bcek_checker.sv @@
// Port-level checks for the barrier cavity energy kick block, with its bind.
`include "barrier_cavity_energy_kick_macros.svh"

module bcek_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bcek_pkg::out_beat_t out_beat_i,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i
);
  import bcek_pkg::*;

  `BCEK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `BCEK_ASSERT(a_sat_rail, clk_i, rst_ni, out_valid_i && out_beat_i.saturated |-> (out_beat_i.energy_out == 32'sh7fffffff) || (out_beat_i.energy_out == 32'sh80000000))
  `BCEK_ASSERT(a_in_stall, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i && !(in_valid_i && in_ready_i))
  `BCEK_ASSERT_NR(a_cfg_rdy, clk_i, cfg_valid_i |-> cfg_ready_i)
  `BCEK_ASSERT_NR(a_rst_idle, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind barrier_cavity_energy_kick bcek_checker u_bcek_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_i  (out_beat_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

@@ verif/barrier_cavity_energy_kick_tb.sv @@
// Self-checking testbench for the barrier cavity energy kick block.
`timescale 1ns / 1ps

module barrier_cavity_energy_kick_tb;
  import bcek_pkg::*;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam longint Q24 = 64'sd16777216;
  localparam longint DegQ16 = 64'sd65536;

  typedef struct {
    int        cfg_set;
    longint    z;
    longint    e;
    bit        typed;
    longint    exp_energy;
    bit        exp_sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  longint unsigned cos_rom [TableDepth];
  longint k_factor, voltage, plus_c, minus_c, plus_w, minus_w;
  out_beat_t pending_energy [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_cnt = 0;

  always #6 clk = ~clk;

  barrier_cavity_energy_kick DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_beat_o(out_beat),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic void build_cos_rom();
    longint unsigned x, x2, term;
    longint sum;
    for (int i = 0; i < TableDepth; i++) begin
      x = (HalfPiQ30 * i) / TableDepth;
      x2 = (x * x) >> 30;
      term = OneQ30;
      sum = OneQ30;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(OneQ30)) sum = OneQ30;
      cos_rom[i] = sum;
    end
  endfunction

  function automatic longint deg_to_rad(longint deg);
    return (deg * 64'sd74961321) >>> 16;
  endfunction

  function automatic bit barrier_kick(longint ph, longint cdeg, longint wdeg,
                                      output longint kick);
    longint c, w, d;
    longint unsigned idx;
    c = deg_to_rad(cdeg);
    w = deg_to_rad(wdeg);
    kick = 0;
    if (w <= 0) return 1'b0;
    if (!(ph > c - w && ph < c + w)) return 1'b0;
    d = ph - c;
    if (d < 0) d = -d;
    idx = (longint'(d) * TableDepth) / w;
    if (idx >= TableDepth) idx = TableDepth - 1;
    kick = (voltage * longint'(cos_rom[idx]) + (64'sd1 <<< 29)) >>> 30;
    return 1'b1;
  endfunction

  function automatic out_beat_t kicked_energy(longint z, longint e);
    longint ph, kick, k, sum;
    out_beat_t r;
    ph = (-(z * k_factor)) >>> 16;
    if (ph < -longint'(PiQ32)) ph += longint'(TwoPiQ32);
    if (ph > longint'(PiQ32)) ph -= longint'(TwoPiQ32);
    kick = 0;
    if (barrier_kick(ph, plus_c, plus_w, k)) kick = k;
    if (barrier_kick(ph, minus_c, minus_w, k)) kick = -k;
    sum = e + kick;
    r.saturated = 1'b0;
    if (sum > 64'sd2147483647) begin sum = 64'sd2147483647; r.saturated = 1'b1; end
    if (sum < -64'sd2147483648) begin sum = -64'sd2147483648; r.saturated = 1'b1; end
    r.energy_out = sum[31:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_Z_TO_PHASE:   k_factor = longint'($signed(data));
      REG_VOLTAGE:      voltage = longint'($signed(data));
      REG_PLUS_CENTRE:  plus_c = longint'($signed(data[24:0]));
      REG_MINUS_CENTRE: minus_c = longint'($signed(data[24:0]));
      REG_PLUS_HALF_W:  plus_w = longint'(data[23:0]);
      REG_MINUS_HALF_W: minus_w = longint'(data[23:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_energy.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Caller is at a falling edge; leaves at a falling edge with valid still up.
  task automatic send_beat(longint z, longint e, bit typed, out_beat_t typed_exp);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat.position_z <= z[31:0];
    in_beat.energy_in <= e[31:0];
    do @(posedge clk); while (!in_ready);
    pending_energy.push_back(typed ? typed_exp : kicked_energy(z, e));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_energy.size() == 0) begin
        $error("unexpected beat: energy_out %0d", $signed(out_beat.energy_out));
        errors++;
      end else begin
        want = pending_energy.pop_front();
        if (out_beat.energy_out !== want.energy_out) begin
          $error("energy_out expected %0d actual %0d",
                 $signed(want.energy_out), $signed(out_beat.energy_out));
          errors++;
        end
        if (out_beat.saturated !== want.saturated) begin
          $error("saturated expected %0d actual %0d", want.saturated, out_beat.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apply_cfg_set(int id);
    wait_idle();
    case (id)
      1: begin
        write_reg(REG_Z_TO_PHASE, 32'h0100_0000);
        write_reg(REG_VOLTAGE, 32'h7fff_ffff);
        write_reg(REG_PLUS_CENTRE, 32'd0);
        write_reg(REG_PLUS_HALF_W, 32'(90 * 65536));
        write_reg(REG_MINUS_CENTRE, 32'(90 * 65536));
        write_reg(REG_MINUS_HALF_W, 32'(30 * 65536));
      end
      2: begin
        write_reg(REG_VOLTAGE, 32'h8000_0000);
        write_reg(REG_PLUS_HALF_W, 32'd0);
        write_reg(REG_MINUS_CENTRE, 32'd0);
        write_reg(REG_MINUS_HALF_W, 32'd1);
        write_reg(REG_SPARE_A, 32'hdead_beef);
      end
      default: ;
    endcase
  endtask

  task automatic random_cfg(int ph);
    logic [31:0] d;
    wait_idle();
    case (ph)
      0: begin
        write_reg(REG_VOLTAGE, 32'h7fff_ffff);
        write_reg(REG_PLUS_CENTRE, 32'(-180 * 65536));
        write_reg(REG_MINUS_CENTRE, 32'(180 * 65536));
        write_reg(REG_PLUS_HALF_W, 32'd11796480);
        write_reg(REG_MINUS_HALF_W, 32'd1);
      end
      1: begin
        write_reg(REG_VOLTAGE, 32'h8000_0000);
        write_reg(REG_PLUS_CENTRE, 32'(180 * 65536));
        write_reg(REG_MINUS_CENTRE, 32'(-180 * 65536));
        write_reg(REG_PLUS_HALF_W, 32'd1);
        write_reg(REG_MINUS_HALF_W, 32'd11796480);
      end
      default: begin
        d = $urandom();
        write_reg(REG_VOLTAGE, d);
        write_reg(REG_PLUS_CENTRE, 32'($signed($urandom_range(23592960)) - 11796480));
        write_reg(REG_MINUS_CENTRE, 32'($signed($urandom_range(23592960)) - 11796480));
        write_reg(REG_PLUS_HALF_W, $urandom_range(11796480, 1));
        write_reg(REG_MINUS_HALF_W, $urandom_range(11796480, 1));
        if (ph % 4 == 3) write_reg(REG_PLUS_CENTRE, $urandom());
        if (ph % 4 == 2) write_reg(REG_MINUS_HALF_W, $urandom());
      end
    endcase
    if (ph == 2) write_reg(REG_Z_TO_PHASE, 32'h8000_0000);
    else if (ph == 3) write_reg(REG_Z_TO_PHASE, 32'h7fff_ffff);
    else if (ph % 3 == 0) write_reg(REG_Z_TO_PHASE, $urandom());
    else write_reg(REG_Z_TO_PHASE, 32'h0100_0000);
    write_reg(($urandom_range(1)) ? REG_SPARE_A : REG_SPARE_B, $urandom());
  endtask

  function automatic longint aimed_z();
    longint c, w, target;
    bit use_minus;
    use_minus = $urandom_range(1);
    c = deg_to_rad(use_minus ? minus_c : plus_c);
    w = deg_to_rad(use_minus ? minus_w : plus_w);
    if (w < 1) w = 1;
    target = c + longint'($urandom_range(32'hffff_ffff)) % (w + w / 8 + 1)
             - longint'($urandom_range(32'hffff_ffff)) % (w + w / 8 + 1);
    target = -(target / 256);
    if (target > 64'sd2147483647) target = 64'sd2147483647;
    if (target < -64'sd2147483648) target = -64'sd2147483648;
    return target;
  endfunction

  stim_row_t plan [] = '{
    '{0, 0, 0, 1, 0, 0},
    '{0, -64'sd2147483648, 64'sd2147483647, 1, 64'sd2147483647, 0},
    '{0, 64'sd2147483647, -64'sd2147483648, 1, -64'sd2147483648, 0},
    '{0, 1, -1, 1, -1, 0},
    '{0, -1, 64'sd12345678, 1, 64'sd12345678, 0},
    '{1, 0, 0, 0, 0, 0},
    '{1, 0, 64'sd2147483647, 0, 0, 0},
    '{1, 0, -64'sd2147483648, 0, 0, 0},
    '{1, -Q24 * 14 / 10, 0, 0, 0, 0},
    '{1, -Q24 * 17 / 10, 0, 0, 0, 0},
    '{1, -Q24 * 3 / 10, 64'sd2000000000, 0, 0, 0},
    '{1, Q24 * 25 / 10, 0, 0, 0, 0},
    '{1, -Q24 * 35 / 10, 0, 0, 0, 0},
    '{1, Q24 * 35 / 10, 0, 0, 0, 0},
    '{1, -64'sd2147483648, 0, 0, 0, 0},
    '{1, 64'sd2147483647, 0, 0, 0, 0},
    '{2, 0, -64'sd2147483648, 0, 0, 0},
    '{2, 0, 64'sd2147483647, 0, 0, 0},
    '{2, 1, 5, 0, 0, 0},
    '{2, -Q24 / 2, 7, 0, 0, 0}
  };

  initial begin
    out_beat_t typed_exp;
    int cur_set;
    longint z, e;
    build_cos_rom();
    k_factor = longint'(ZToPhaseReset);
    voltage = 0;
    plus_c = 0;
    minus_c = 0;
    plus_w = DegQ16;
    minus_w = DegQ16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_set = 0;
    foreach (plan[i]) begin
      if (plan[i].cfg_set != cur_set) begin
        in_valid <= 1'b0;
        cur_set = plan[i].cfg_set;
        apply_cfg_set(cur_set);
      end
      typed_exp.energy_out = plan[i].exp_energy[31:0];
      typed_exp.saturated = plan[i].exp_sat;
      send_beat(plan[i].z, plan[i].e, plan[i].typed, typed_exp);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      random_cfg(ph);
      quiet = (ph == 4);
      for (int n = 0; n < 145; n++) begin
        if (ph == 6 && n == 10) hold_go = 1'b1;
        z = ($urandom_range(3) != 0) ? aimed_z() : longint'($signed($urandom()));
        e = longint'($signed($urandom()));
        if ($urandom_range(15) == 0) e = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        send_beat(z, e, 1'b0, typed_exp);
      end
      in_valid <= 1'b0;
      quiet = 1'b0;
    end

    wait_idle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bcek_pkg.sv
hdl/bcek_cos_rom.sv
hdl/barrier_cavity_energy_kick.sv
hdl/bcek_checker.sv
verif/barrier_cavity_energy_kick_tb.sv
